FILE: sv/fgsc_pkg.sv
// shared types and constants of the fuel gauge sample conditioner
`timescale 1ns / 1ps
`default_nettype none

package fgsc_pkg;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_RCOMP_BASE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_HOT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_COLD  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_LEVEL  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_LEVEL = 3'd4;

  localparam logic [9:0] FULL_LEVEL_RST = 10'd1000;

  // arithmetic constants
  localparam logic [14:0]        SOC_SCALE      = 15'd19531;
  localparam logic [19:0]        EMPTY_SCALE    = 20'd1000000;
  localparam logic signed [14:0] SPAN_SCALE     = 15'sd10000;
  localparam logic [6:0]         CAP_MAX        = 7'd100;
  localparam logic signed [11:0] TEMP_DEFAULT   = 12'sd250;
  localparam logic [12:0]        DIV10_K        = 13'd6554;    // ceil(2^16 / 10)
  localparam logic signed [9:0]  TEMP_REF       = 10'sd20;
  localparam logic [9:0]         MILLI          = 10'd1000;
  localparam logic [18:0]        DIV1000_K      = 19'd268436;  // ceil(2^28 / 1000)
  localparam logic [17:0]        RCOMP_SAT_LIM  = 18'd256000;
  localparam logic [7:0]         RCOMP_MAX      = 8'd255;

  // divider
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [15:0]        vcell_raw;
    logic               vcell_ok;
    logic [15:0]        soc_raw;
    logic               soc_ok;
    logic signed [11:0] temp_deci_c;
    logic               temp_ok;
  } sample_t;

  typedef struct packed {
    logic [12:0] voltage_mv;
    logic [6:0]  capacity_pct;
    logic [7:0]  rcomp_value;
    logic        changed;
  } result_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic absv;
    logic rc1;
    logic rc2;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ABS,
    ST_RC1,
    ST_RC2,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

FILE: sv/fgsc_if.sv
// request channels of the fuel gauge sample conditioner
`timescale 1ns / 1ps
`default_nettype none

interface fgsc_sample_if;
  import fgsc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fgsc_result_if;
  import fgsc_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/fgsc_ctrl.sv
// sequencer of the fuel gauge sample conditioner
`timescale 1ns / 1ps
`default_nettype none

module fgsc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output fgsc_pkg::cmd_t       cmd
);
  import fgsc_pkg::*;

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] step, step_next;
  logic                 out_valid_next;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no request is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_ABS;
      end
      ST_ABS: begin
        cmd.absv   = 1'b1;
        state_next = ST_RC1;
      end
      ST_RC1: begin
        cmd.rc1    = 1'b1;
        state_next = ST_RC2;
      end
      ST_RC2: begin
        cmd.rc2    = 1'b1;
        step_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/fgsc_datapath.sv
// datapath of the fuel gauge sample conditioner: scaling, divider, compensation
`timescale 1ns / 1ps
`default_nettype none

module fgsc_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fgsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fgsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire fgsc_pkg::sample_t                in_data,
  input  wire fgsc_pkg::cmd_t                   cmd,
  output fgsc_pkg::result_t                     out_data
);
  import fgsc_pkg::*;

  // configuration
  logic [7:0]  rcomp_base;
  logic [15:0] coeff_hot;
  logic [15:0] coeff_cold;
  logic [9:0]  full_level;
  logic [9:0]  empty_level;

  // history
  logic [12:0] last_voltage;
  logic [6:0]  last_capacity;

  // load stage
  logic [12:0]        volt_new;
  logic               vok;
  logic               sok;
  logic [30:0]        prod_a;
  logic [29:0]        prod_b;
  logic signed [10:0] lvl_diff;
  logic [11:0]        tabs;
  logic               tneg;

  // prep stage
  logic signed [31:0] num;
  logic signed [24:0] den;
  logic [7:0]         tq;

  // abs stage and divider
  logic [31:0]        quo;
  logic [23:0]        rem;
  logic [23:0]        den_mag;
  logic               q_neg;
  logic               den_zero;
  logic signed [9:0]  tdiff;
  logic [15:0]        slope;

  // compensation stages
  logic signed [27:0] rval;
  logic [7:0]         rcomp;

  // combinational helpers
  logic [14:0]        v_times5;
  logic signed [11:0] tsel;
  logic [24:0]        tq_prod;
  logic signed [9:0]  t_whole;
  logic signed [9:0]  t_rel;
  logic signed [16:0] slope_s;
  logic signed [26:0] rc_prod;
  logic [17:0]        base_k;
  logic [36:0]        rq_prod;
  logic [24:0]        rem_sh;
  logic [25:0]        trial;
  logic [6:0]         cap_calc;
  logic [12:0]        volt_out;
  logic [6:0]         cap_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      rcomp_base  <= '0;
      coeff_hot   <= '0;
      coeff_cold  <= '0;
      full_level  <= FULL_LEVEL_RST;
      empty_level <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RCOMP_BASE:  rcomp_base  <= cfg_data[7:0];
        REG_COEFF_HOT:   coeff_hot   <= cfg_data;
        REG_COEFF_COLD:  coeff_cold  <= cfg_data;
        REG_FULL_LEVEL:  full_level  <= cfg_data[9:0];
        REG_EMPTY_LEVEL: empty_level <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign v_times5 = in_data.vcell_raw[15:4] * 15'd5;
  assign tsel     = in_data.temp_ok ? in_data.temp_deci_c : TEMP_DEFAULT;
  assign tq_prod  = tabs * DIV10_K;
  assign t_whole  = tneg ? -$signed({2'b00, tq}) : $signed({2'b00, tq});
  assign t_rel    = t_whole - TEMP_REF;
  assign slope_s  = $signed({1'b0, slope});
  assign rc_prod  = tdiff * slope_s;
  assign base_k   = rcomp_base * MILLI;
  assign rq_prod  = rval[17:0] * DIV1000_K;
  assign rem_sh   = {rem, quo[31]};
  assign trial    = {1'b0, rem_sh} - {2'b00, den_mag};

  always_comb begin
    if (den_zero || q_neg) begin
      cap_calc = '0;
    end else if (quo > 32'(CAP_MAX)) begin
      cap_calc = CAP_MAX;
    end else begin
      cap_calc = quo[6:0];
    end
  end

  assign volt_out = vok ? volt_new : last_voltage;
  assign cap_out  = sok ? cap_calc : last_capacity;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      volt_new <= v_times5[14:2];
      vok      <= in_data.vcell_ok;
      sok      <= in_data.soc_ok;
      prod_a   <= in_data.soc_raw * SOC_SCALE;
      prod_b   <= empty_level * EMPTY_SCALE;
      lvl_diff <= $signed({1'b0, full_level}) - $signed({1'b0, empty_level});
      tneg     <= tsel[11];
      tabs     <= tsel[11] ? (~tsel + 12'd1) : tsel;
    end
    if (cmd.prep) begin
      num <= $signed({1'b0, prod_a}) - $signed({2'b00, prod_b});
      den <= lvl_diff * SPAN_SCALE;
      tq  <= tq_prod[23:16];
    end
    if (cmd.absv) begin
      quo      <= num[31] ? (~num + 32'd1) : num;
      rem      <= '0;
      den_mag  <= den[24] ? 24'(~den + 25'd1) : den[23:0];
      q_neg    <= num[31] ^ den[24];
      den_zero <= (den == '0);
      tdiff    <= t_rel;
      if (t_rel > 10'sd0) begin
        slope <= coeff_hot;
      end else if (t_rel < 10'sd0) begin
        slope <= coeff_cold;
      end else begin
        slope <= '0;
      end
    end
    if (cmd.rc1) begin
      rval <= $signed({10'd0, base_k}) - 28'(rc_prod);
    end
    if (cmd.rc2) begin
      if (rval[27]) begin
        rcomp <= '0;
      end else if (rval >= $signed({10'd0, RCOMP_SAT_LIM})) begin
        rcomp <= RCOMP_MAX;
      end else begin
        rcomp <= rq_prod[35:28];
      end
    end
    // restoring divide, one quotient bit a cycle
    if (cmd.div_step) begin
      if (!trial[25]) begin
        rem <= trial[23:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[23:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      out_data.voltage_mv   <= volt_out;
      out_data.capacity_pct <= cap_out;
      out_data.rcomp_value  <= rcomp;
      out_data.changed      <= (volt_out != last_voltage) || (cap_out != last_capacity);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_voltage  <= '0;
      last_capacity <= '0;
    end else if (cmd.finish) begin
      last_voltage  <= volt_out;
      last_capacity <= cap_out;
    end
  end

endmodule

`default_nettype wire

FILE: sv/fuel_gauge_sample_conditioner_unit.sv
// top level of the fuel gauge sample conditioner
`timescale 1ns / 1ps
`default_nettype none

// each request on the sample channel carries one poll of the gauge (raw cell
// voltage, raw charge word, temperature in tenths of a degree, each with an ok
// flag) and yields exactly one request on the result channel. from acceptance
// until the block can take the next one, a poll passes the load, prep, abs,
// rc1 and rc2 steps of scaling and compensation set-up, the bit-serial signed
// divider that rescales the charge word, and the finish step. the result sits
// in an output register, so a new poll is taken while the last result waits;
// the next result is held back only if the previous one has still not been
// taken. a failed reading repeats the last reported value, a missing
// temperature counts as 25 degrees. configuration writes (index 0 base, 1 hot
// slope, 2 cold slope, 3 full level, 4 empty level) are meant for idle time.
module fuel_gauge_sample_conditioner_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fgsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fgsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  fgsc_sample_if.sink                           sample,
  fgsc_result_if.source                         result
);
  import fgsc_pkg::*;

  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  // sequencer: walks each poll through the datapath stages
  fgsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  // datapath: config registers, history, divider and output register
  fgsc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (sample.data),
    .cmd       (cmd),
    .out_data  (result.data)
  );

  assign sample.ready = in_ready;
  assign result.valid = out_valid;

endmodule

`default_nettype wire
